// ----- src/bfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfr_pkg: shared definitions for the 3x3 RGB box filter
// Sizes, register indexes, the controller/datapath command and status
// structs, and the reciprocal table used to divide by the neighbor count.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// Frame geometry and pixel sizes.
	localparam int MAX_WIDTH    = 1024;
	localparam int CHANNEL_BITS = 8;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int WIDTH_W      = 11;
	localparam int HEIGHT_W     = 16;
	localparam int ROW_W        = HEIGHT_W + 1;
	localparam int PIX_W        = 3 * CHANNEL_BITS;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [WIDTH_W-1:0]   WIDTH_RESET      = 11'd640;
	localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET     = 16'd480;

	// Arithmetic sizes: a sum of nine channels, a reciprocal scaled by 2^16.
	localparam int SUM_W       = CHANNEL_BITS + 4;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             capture;   // take the pixel and read the line stores
		logic [COL_W-1:0] addr;      // line store column
		logic             shift;     // shift the window, update the line stores
		logic             sum_load;  // register the masked window sums
		logic             mul;       // multiply the sums by the reciprocal
		logic             load_out;  // load the output register
		logic [2:0]       row_en;    // window rows inside the image
		logic [2:0]       col_en;    // window columns inside the image
		logic             last;      // result is the last pixel of the frame
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_room;  // output register is free or is emptied this cycle
	} dp_stat_t;

	// Reciprocal of the neighbor count, rounded up, scaled by 2^RECIP_SHIFT.
	// Exact after truncation for any sum of at most nine channel values.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] rows,
		input logic [1:0] cols);
		logic [3:0] cnt;
		cnt = {2'b00, rows} * {2'b00, cols};
		case (cnt)
			4'd2:    recip_of = 17'd32768;
			4'd3:    recip_of = 17'd21846;
			4'd4:    recip_of = 17'd16384;
			4'd6:    recip_of = 17'd10923;
			4'd9:    recip_of = 17'd7282;
			default: recip_of = 17'd65536;
		endcase
	endfunction

endpackage

// ----- src/box_filter_3x3_rgb_unit.sv -----
// ----------------------------------------------------------------------------
// Sequence: a beat that causes a result passes the read, sum (skipped at a
// row end), multiply and output states before the result shows on the output,
// and an output stall holds it in the output state. No new beat is taken until
// the sequence is back in idle.
// Reset clears the frame registers to 640x480, the raster position and the
// window; the line store memory keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_unit: 3x3 mean filter over an RGB raster stream
// Each result is the per-channel mean of the neighbors inside the image,
// truncated. Results lag by one row plus one pixel; width+1 drain beats
// after the frame flush the last results.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_unit
	import bfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,   // in_red, in_green, in_blue
	input  logic                  s_axis_tuser,   // drain
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,   // out_red, out_green, out_blue
	output logic                  m_axis_tlast,   // frame_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer and frame registers.
	bfr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.stat          (stat),
		.cmd           (cmd)
	);

	// Line stores, window and arithmetic.
	bfr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.pix_data      (s_axis_tdata),
		.pix_drain     (s_axis_tuser),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- src/bfr_datapath.sv -----
// ----------------------------------------------------------------------------
// bfr_datapath: line stores, 3x3 window and mean arithmetic
// Holds the two previous rows in one dual-row memory, shifts the window,
// sums the neighbors that lie inside the image and divides by their count
// through a reciprocal multiply. Ends in the output register.
// ----------------------------------------------------------------------------
module bfr_datapath
	import bfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [PIX_W-1:0] pix_data,
	input  logic             pix_drain,
	output dp_stat_t         stat,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [PIX_W-1:0] m_axis_tdata,
	output logic             m_axis_tlast
);

	// Line store entry: upper row in the low half, middle row in the high half.
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [COL_W-1:0]   addr_q;
	logic [PIX_W-1:0]   px_q;
	logic [PIX_W-1:0]   win_q [3][3];
	logic [SUM_W-1:0]   sum_d [3];
	logic [SUM_W-1:0]   sum_q [3];
	logic [PROD_W-1:0]  prod_q [3];
	logic [1:0]         rows;
	logic [1:0]         cols;
	logic [RECIP_W-1:0] recip;
	logic               out_valid_q;
	logic [PIX_W-1:0]   out_data_q;
	logic               out_last_q;

	// Line store: read at capture, written back in the next cycle at the shift.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= line_mem[cmd.addr];
		end
		if (cmd.shift) begin
			line_mem[addr_q] <= {px_q, rd_q[2*PIX_W-1:PIX_W]};
		end
	end

	// Captured pixel and its column; a drain beat counts as a black pixel.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q <= cmd.addr;
			px_q   <= pix_drain ? '0 : pix_data;
		end
	end

	// The 3x3 window shifts left; the new column comes from the stores and the pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_q[PIX_W-1:0];
			win_q[1][2] <= rd_q[2*PIX_W-1:PIX_W];
			win_q[2][2] <= px_q;
		end
	end

	// Per-channel sum over the window positions that lie inside the image.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (cmd.row_en[i] && cmd.col_en[j]) begin
						sum_d[ch] = sum_d[ch]
							+ SUM_W'(win_q[i][j][ch*CHANNEL_BITS +: CHANNEL_BITS]);
					end
				end
			end
		end
	end

	// Neighbor count as rows times columns, turned into a reciprocal.
	assign rows  = {1'b0, cmd.row_en[0]} + {1'b0, cmd.row_en[1]} + {1'b0, cmd.row_en[2]};
	assign cols  = {1'b0, cmd.col_en[0]} + {1'b0, cmd.col_en[1]} + {1'b0, cmd.col_en[2]};
	assign recip = recip_of(rows, cols);

	// Sum and multiply registers.
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.sum_load) begin
				sum_q[ch] <= sum_d[ch];
			end
			if (cmd.mul) begin
				prod_q[ch] <= PROD_W'(sum_q[ch]) * PROD_W'(recip);
			end
		end
	end

	// Output register: filled by the controller, emptied by the sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int ch = 0; ch < 3; ch++) begin
				out_data_q[ch*CHANNEL_BITS +: CHANNEL_BITS] <=
					prod_q[ch][RECIP_SHIFT +: CHANNEL_BITS];
			end
			out_last_q <= cmd.last;
		end
	end

	assign stat.out_room  = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid  = out_valid_q;
	assign m_axis_tdata   = out_data_q;
	assign m_axis_tlast   = out_last_q;

	// A new result is loaded only when the previous one is gone or leaving.
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_axis_tready))
		else $error("output register overwritten while full");

endmodule

// ----- src/bfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfr_ctrl: sequencer for the 3x3 RGB box filter
// Holds the frame registers and the raster position, decides per beat
// which result it causes and with which neighbors, and steps the datapath.
// ----------------------------------------------------------------------------
module bfr_ctrl
	import bfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_stat_t              stat,
	output dp_cmd_t               cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                left_end_q;
	logic                mid_emit_q;
	logic [2:0]          row_en_q;
	logic [2:0]          col_en_q;
	logic                last_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [ROW_W-1:0]    h_ext;
	logic [ROW_W-1:0]    h_ext_p1;
	logic                accept;
	logic                cfg_write;
	logic                row_wrap;
	logic                left_end;
	logic                mid_emit;
	logic                last_d;
	logic [2:0]          row_en_d;
	logic [2:0]          col_en_d;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// Effective frame size: zero counts as one, width is capped at the store depth.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	end

	assign h_ext    = ROW_W'(h_eff);
	assign h_ext_p1 = h_ext + ROW_W'(1);
	assign row_wrap = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= w_eff;

	// A beat at column zero finishes the last pixel of the row two above;
	// any other beat finishes the pixel one row up and one column left.
	always_comb begin
		left_end = (col_q == '0) && (row_q >= ROW_W'(2)) && (row_q <= h_ext_p1);
		mid_emit = (col_q != '0) && (row_q >= ROW_W'(1)) && (row_q <= h_ext);
		last_d   = left_end && (row_q == h_ext_p1);
		if (left_end) begin
			row_en_d = {row_q <= h_ext, 1'b1, row_q >= ROW_W'(3)};
			col_en_d = {1'b1, w_eff >= WIDTH_W'(2), 1'b0};
		end else begin
			row_en_d = {row_q < h_ext, 1'b1, row_q >= ROW_W'(2)};
			col_en_d = {1'b1, 1'b1, col_q >= COL_W'(2)};
		end
	end

	// Frame registers and raster position; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WIDTH_W-1:0];
			end else begin
				height_q <= cfg_data[HEIGHT_W-1:0];
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_d) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Per-beat result plan, held until the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_end_q <= 1'b0;
			mid_emit_q <= 1'b0;
			row_en_q   <= '0;
			col_en_q   <= '0;
			last_q     <= 1'b0;
		end else if (accept) begin
			left_end_q <= left_end;
			mid_emit_q <= mid_emit;
			row_en_q   <= row_en_d;
			col_en_q   <= col_en_d;
			last_q     <= last_d;
		end
	end

	// Sequence: read stores, shift (sums taken before the shift at a row end), sum after
	// the shift otherwise, multiply, then wait for the output register; no result: back to idle.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (left_end_q) begin
					state_d = S_DIV;
				end else if (mid_emit_q) begin
					state_d = S_SUM;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SUM: state_d = S_DIV;
			S_DIV: state_d = S_OUT;
			S_OUT: begin
				if (stat.out_room) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath commands.
	assign s_axis_tready = (state_q == S_IDLE);
	assign cmd.capture   = accept;
	assign cmd.addr      = col_q;
	assign cmd.shift     = (state_q == S_READ);
	assign cmd.sum_load  = ((state_q == S_READ) && left_end_q) || (state_q == S_SUM);
	assign cmd.mul       = (state_q == S_DIV);
	assign cmd.load_out  = (state_q == S_OUT) && stat.out_room;
	assign cmd.row_en    = row_en_q;
	assign cmd.col_en    = col_en_q;
	assign cmd.last      = last_q;

	// The column stays inside the row and the row never passes the drain row.
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WIDTH_W'(col_q) < w_eff)
		else $error("column position beyond image width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_ext_p1)
		else $error("row position beyond the drain row");

	// Post-shift sums only follow the store read.
	a_sum_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> ($past(state_q) == S_READ))
		else $error("window sum without a preceding shift");

	// The multiply always sees freshly registered sums.
	a_div_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ($past(state_q) == S_READ || $past(state_q) == S_SUM))
		else $error("multiply without fresh sums");

endmodule
